// ----- src/tsrb_pkg.sv -----
// Package for the twin stack with recycle bin.
// Holds opcodes, status codes, payload widths and the controller/datapath
// command and status types. Depends on nothing.
package tsrb_pkg;

    // Payload widths
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int ST_W   = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTORE  = 3'd2;
    localparam logic [OP_W-1:0] OP_DISCARD  = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW_PRI = 3'd4;
    localparam logic [OP_W-1:0] OP_SHOW_BIN = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_PRI_FULL  = 3'd1;
    localparam logic [ST_W-1:0] ST_PRI_EMPTY = 3'd2;
    localparam logic [ST_W-1:0] ST_BIN_FULL  = 3'd3;
    localparam logic [ST_W-1:0] ST_BIN_EMPTY = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_OP    = 3'd5;

    // Read address source
    typedef enum logic [1:0] {
        RD_PRI_TOP = 2'd0,
        RD_BIN_TOP = 2'd1,
        RD_WALK    = 2'd2
    } t_rd_sel;

    // Write address and data source
    typedef enum logic [1:0] {
        WR_PUSH     = 2'd0,
        WR_PRI_MOVE = 2'd1,
        WR_BIN_MOVE = 2'd2
    } t_wr_sel;

    // Element field source of an emitted result
    typedef enum logic [1:0] {
        EL_ZERO = 2'd0,
        EL_PUSH = 2'd1,
        EL_RD   = 2'd2
    } t_el_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic            load_item;
        logic            rd_en;
        t_rd_sel         rd_sel;
        logic            wr_en;
        t_wr_sel         wr_sel;
        logic            emit;
        t_el_sel         el_sel;
        logic [ST_W-1:0] status;
        logic            last;
        logic            pri_inc;
        logic            pri_dec;
        logic            bin_inc;
        logic            bin_dec;
        logic            walk_load;
        logic            walk_bin;
        logic            walk_dec;
    } t_cmd;

    localparam t_cmd CMD_NOP = t_cmd'(0);

    // Status from datapath to controller
    typedef struct packed {
        logic pri_empty;
        logic pri_full;
        logic bin_empty;
        logic bin_full;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

// ----- src/tsrb_if.sv -----
// Handshake channels of the twin stack: input items and result items.
// Depends on tsrb_pkg for payload widths.
interface tsrb_in_if;
    logic                              valid;
    logic                              ready;
    logic [tsrb_pkg::OP_W-1:0]         opcode;
    logic signed [tsrb_pkg::DATA_W-1:0] push_value;

    modport source (output valid, opcode, push_value, input ready);
    modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface tsrb_out_if;
    logic                               valid;
    logic                               ready;
    logic [tsrb_pkg::ST_W-1:0]          status;
    logic signed [tsrb_pkg::DATA_W-1:0] element;
    logic                               last_item;

    modport source (output valid, status, element, last_item, input ready);
    modport sink   (input valid, status, element, last_item, output ready);
endinterface

// ----- src/tsrb_ctrl.sv -----
// Controller of the twin stack: decodes one item at a time, checks the
// stack limits and sequences reads, writes and result emission.
// Depends on tsrb_pkg.
module tsrb_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [tsrb_pkg::OP_W-1:0] i_opcode,
    output logic                      o_ready,
    input  tsrb_pkg::t_sts            i_sts,
    output tsrb_pkg::t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [tsrb_pkg::OP_W-1:0] r_op;
    tsrb_pkg::t_cmd            cmd;
    logic                      accept;

    assign o_ready = (r_state == S_IDLE) && i_rst_n;
    assign accept  = o_ready && i_valid;
    assign o_cmd   = cmd;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the opcode of the item in work
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_opcode;
        end
    end

    // Decode and sequence
    always_comb begin
        n_state = r_state;
        cmd     = tsrb_pkg::CMD_NOP;
        cmd.status = tsrb_pkg::ST_OK;
        cmd.last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    tsrb_pkg::OP_PUSH: begin
                        if (i_sts.out_free) begin
                            cmd.emit    = 1'b1;
                            n_state     = S_IDLE;
                            if (i_sts.pri_full) begin
                                cmd.status = tsrb_pkg::ST_PRI_FULL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = tsrb_pkg::WR_PUSH;
                                cmd.pri_inc = 1'b1;
                                cmd.el_sel  = tsrb_pkg::EL_PUSH;
                            end
                        end
                    end
                    tsrb_pkg::OP_POP: begin
                        if (i_sts.pri_empty || i_sts.bin_full) begin
                            if (i_sts.out_free) begin
                                cmd.emit   = 1'b1;
                                cmd.status = i_sts.pri_empty ? tsrb_pkg::ST_PRI_EMPTY
                                                             : tsrb_pkg::ST_BIN_FULL;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = tsrb_pkg::RD_PRI_TOP;
                            n_state    = S_WAIT;
                        end
                    end
                    tsrb_pkg::OP_RESTORE: begin
                        if (i_sts.bin_empty || i_sts.pri_full) begin
                            if (i_sts.out_free) begin
                                cmd.emit   = 1'b1;
                                cmd.status = i_sts.bin_empty ? tsrb_pkg::ST_BIN_EMPTY
                                                             : tsrb_pkg::ST_PRI_FULL;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = tsrb_pkg::RD_BIN_TOP;
                            n_state    = S_WAIT;
                        end
                    end
                    tsrb_pkg::OP_DISCARD: begin
                        if (i_sts.bin_empty) begin
                            if (i_sts.out_free) begin
                                cmd.emit   = 1'b1;
                                cmd.status = tsrb_pkg::ST_BIN_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = tsrb_pkg::RD_BIN_TOP;
                            n_state    = S_WAIT;
                        end
                    end
                    tsrb_pkg::OP_SHOW_PRI: begin
                        if (i_sts.pri_empty) begin
                            if (i_sts.out_free) begin
                                cmd.emit   = 1'b1;
                                cmd.status = tsrb_pkg::ST_PRI_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = tsrb_pkg::RD_PRI_TOP;
                            cmd.walk_load = 1'b1;
                            cmd.walk_bin  = 1'b0;
                            n_state       = S_WAIT;
                        end
                    end
                    tsrb_pkg::OP_SHOW_BIN: begin
                        if (i_sts.bin_empty) begin
                            if (i_sts.out_free) begin
                                cmd.emit   = 1'b1;
                                cmd.status = tsrb_pkg::ST_BIN_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = tsrb_pkg::RD_BIN_TOP;
                            cmd.walk_load = 1'b1;
                            cmd.walk_bin  = 1'b1;
                            n_state       = S_WAIT;
                        end
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.status = tsrb_pkg::ST_BAD_OP;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                // Read data is valid here; finish the move or the walk step
                if (i_sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.el_sel = tsrb_pkg::EL_RD;
                    n_state    = S_IDLE;
                    unique case (r_op)
                        tsrb_pkg::OP_POP: begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = tsrb_pkg::WR_BIN_MOVE;
                            cmd.pri_dec = 1'b1;
                            cmd.bin_inc = 1'b1;
                        end
                        tsrb_pkg::OP_RESTORE: begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = tsrb_pkg::WR_PRI_MOVE;
                            cmd.bin_dec = 1'b1;
                            cmd.pri_inc = 1'b1;
                        end
                        tsrb_pkg::OP_DISCARD: begin
                            cmd.bin_dec = 1'b1;
                        end
                        default: begin
                            // Show: emit this entry and fetch the one below
                            cmd.last = i_sts.walk_last;
                            if (!i_sts.walk_last) begin
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = tsrb_pkg::RD_WALK;
                                cmd.walk_dec = 1'b1;
                                n_state      = S_WAIT;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tsrb_dp.sv -----
// Datapath of the twin stack: shared element memory, stack counts, walk
// offset, item register and result output register.
// Depends on tsrb_pkg.
module tsrb_dp #(
    parameter int STACK_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tsrb_pkg::t_cmd                     i_cmd,
    output tsrb_pkg::t_sts                     o_sts,
    input  logic signed [tsrb_pkg::DATA_W-1:0] i_push_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [tsrb_pkg::ST_W-1:0]          o_out_status,
    output logic signed [tsrb_pkg::DATA_W-1:0] o_out_element,
    output logic                               o_out_last
);

    localparam int ENTRIES = 2 * STACK_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam logic [ADDR_W-1:0] BIN_BASE = ADDR_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(STACK_DEPTH);

    logic [tsrb_pkg::DATA_W-1:0] r_mem [0:ENTRIES-1];
    logic [tsrb_pkg::DATA_W-1:0] r_rd_data;
    logic [tsrb_pkg::DATA_W-1:0] r_push_value;
    logic [CNT_W-1:0]            r_pri_cnt, n_pri_cnt;
    logic [CNT_W-1:0]            r_bin_cnt, n_bin_cnt;
    logic [CNT_W-1:0]            r_off;
    logic                        r_walk_bin;
    logic                        r_out_valid;
    logic [tsrb_pkg::ST_W-1:0]   r_out_status;
    logic [tsrb_pkg::DATA_W-1:0] r_out_element;
    logic                        r_out_last;

    logic [ADDR_W-1:0]           pri_top, bin_top, walk_addr, walk_base;
    logic [ADDR_W-1:0]           rd_addr, wr_addr;
    logic [tsrb_pkg::DATA_W-1:0] wr_data, el_data;
    logic                        out_free;

    // Address arithmetic
    assign pri_top   = ADDR_W'(r_pri_cnt) - ADDR_W'(1);
    assign bin_top   = BIN_BASE + ADDR_W'(r_bin_cnt) - ADDR_W'(1);
    assign walk_base = r_walk_bin ? BIN_BASE : '0;
    assign walk_addr = walk_base + ADDR_W'(r_off) - ADDR_W'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            tsrb_pkg::RD_PRI_TOP: rd_addr = pri_top;
            tsrb_pkg::RD_BIN_TOP: rd_addr = bin_top;
            tsrb_pkg::RD_WALK:    rd_addr = walk_addr;
            default:              rd_addr = pri_top;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            tsrb_pkg::WR_PUSH: begin
                wr_addr = ADDR_W'(r_pri_cnt);
                wr_data = r_push_value;
            end
            tsrb_pkg::WR_PRI_MOVE: begin
                wr_addr = ADDR_W'(r_pri_cnt);
                wr_data = r_rd_data;
            end
            tsrb_pkg::WR_BIN_MOVE: begin
                wr_addr = BIN_BASE + ADDR_W'(r_bin_cnt);
                wr_data = r_rd_data;
            end
            default: begin
                wr_addr = ADDR_W'(r_pri_cnt);
                wr_data = r_rd_data;
            end
        endcase
    end

    // Element memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Hold the push value of the item in work
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_push_value <= i_push_value;
        end
    end

    // Stack counts
    always_comb begin
        n_pri_cnt = r_pri_cnt;
        n_bin_cnt = r_bin_cnt;
        if (i_cmd.pri_inc) begin
            n_pri_cnt = r_pri_cnt + CNT_W'(1);
        end else if (i_cmd.pri_dec) begin
            n_pri_cnt = r_pri_cnt - CNT_W'(1);
        end
        if (i_cmd.bin_inc) begin
            n_bin_cnt = r_bin_cnt + CNT_W'(1);
        end else if (i_cmd.bin_dec) begin
            n_bin_cnt = r_bin_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_cnt <= '0;
            r_bin_cnt <= '0;
        end else begin
            r_pri_cnt <= n_pri_cnt;
            r_bin_cnt <= n_bin_cnt;
        end
    end

    // Walk offset of the entry last read during a show
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_load) begin
            r_walk_bin <= i_cmd.walk_bin;
            r_off      <= i_cmd.walk_bin ? (r_bin_cnt - CNT_W'(1))
                                         : (r_pri_cnt - CNT_W'(1));
        end else if (i_cmd.walk_dec) begin
            r_off <= r_off - CNT_W'(1);
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.el_sel)
            tsrb_pkg::EL_ZERO: el_data = '0;
            tsrb_pkg::EL_PUSH: el_data = r_push_value;
            tsrb_pkg::EL_RD:   el_data = r_rd_data;
            default:           el_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status  <= i_cmd.status;
            r_out_element <= el_data;
            r_out_last    <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out_status;
    assign o_out_element = r_out_element;
    assign o_out_last    = r_out_last;

    assign o_sts.pri_empty = (r_pri_cnt == '0);
    assign o_sts.pri_full  = (r_pri_cnt == CNT_FULL);
    assign o_sts.bin_empty = (r_bin_cnt == '0);
    assign o_sts.bin_full  = (r_bin_cnt == CNT_FULL);
    assign o_sts.walk_last = (r_off == '0);
    assign o_sts.out_free  = out_free;

endmodule

// ----- src/twin_stack_with_recycle_bin_top.sv -----
// Top level of the twin stack with recycle bin: controller plus datapath.
// Depends on tsrb_pkg, tsrb_if, tsrb_ctrl and tsrb_dp.
//
//   Channel  Dir  Modport  Payload
//   i_in     in   sink     opcode[2:0], push_value[31:0] signed
//   o_out    out  source   status[2:0], element[31:0] signed, last_item
//
// One item is in work at a time. Push, bad opcodes and every error load the
// result register from the execute state; pop, restore and discard load it
// from the wait state, after one registered read of the shared memory, and
// pop and restore then write the moved entry. A show of n entries makes one
// memory read per entry. Reset is synchronous and clears both counts and the
// output valid flag; memory contents are not cleared. A stalled output holds
// the sequence in place.
module twin_stack_with_recycle_bin_top #(
    parameter int STACK_DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsrb_in_if.sink   i_in,
    tsrb_out_if.source o_out
);

    tsrb_pkg::t_cmd cmd;
    tsrb_pkg::t_sts sts;

    tsrb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_opcode (i_in.opcode),
        .o_ready  (i_in.ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    tsrb_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_push_value  (i_in.push_value),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_status  (o_out.status),
        .o_out_element (o_out.element),
        .o_out_last    (o_out.last_item)
    );

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted into an occupied output register");

    // Never grow a full stack
    a_pri_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pri_inc |-> !sts.pri_full)
        else $error("primary stack grown past its depth");

    a_bin_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.bin_inc |-> !sts.bin_full)
        else $error("bin grown past its depth");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in work");

endmodule

// ----- tb/twin_stack_with_recycle_bin_top_tb.sv -----
// Self-checking testbench for twin_stack_with_recycle_bin_top: directed and random
// stack operations under varied handshake pressure, checked against a behavioral predictor.
// Depends on tsrb_pkg, tsrb_if and the top-level RTL.
`timescale 1ns / 1ps

module twin_stack_with_recycle_bin_top_tb;

    localparam int STACK_DEPTH = 8;
    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_SLACK = 2 * STACK_DEPTH + 8;
    localparam int HOLD_CYCLES = 300;

    // Opcodes the block rejects
    localparam logic [tsrb_pkg::OP_W-1:0] OP_BAD_LO = 3'd6;
    localparam logic [tsrb_pkg::OP_W-1:0] OP_BAD_HI = 3'd7;

    // Random operation mixes
    typedef enum int {MIX_FILL, MIX_BIN_FILL, MIX_DRAIN} t_mix;

    typedef struct {
        logic [tsrb_pkg::ST_W-1:0]          status;
        logic signed [tsrb_pkg::DATA_W-1:0] element;
        logic                               last_item;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsrb_in_if  in_ch ();
    tsrb_out_if out_ch ();

    twin_stack_with_recycle_bin_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predicted stack contents and depths
    logic signed [tsrb_pkg::DATA_W-1:0] pri_stack [STACK_DEPTH];
    logic signed [tsrb_pkg::DATA_W-1:0] bin_stack [STACK_DEPTH];
    int pri_depth;
    int bin_depth;

    t_result pending_results [$];

    int  items_sent;
    int  results_checked;
    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  hold_left;
    bit  status_seen [8];

    always #(CLK_HALF) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("twin_stack_with_recycle_bin_top_tb: done, errors");
            $finish;
        end
    end

    // Drive output ready: long hold-off on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d element %0d last_item %0b",
                       out_ch.status, out_ch.element, out_ch.last_item);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                status_seen[exp_res.status] = 1'b1;
                if (out_ch.status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.element !== exp_res.element) begin
                    $error("element: expected %0d, actual %0d",
                           exp_res.element, out_ch.element);
                    error_count++;
                end
                if (out_ch.last_item !== exp_res.last_item) begin
                    $error("last_item: expected %0b, actual %0b",
                           exp_res.last_item, out_ch.last_item);
                    error_count++;
                end
            end
        end
    end

    function automatic void expect_result(input logic [tsrb_pkg::ST_W-1:0] status,
                                          input logic signed [tsrb_pkg::DATA_W-1:0] element,
                                          input logic last_item);
        t_result r;
        r.status    = status;
        r.element   = element;
        r.last_item = last_item;
        pending_results.push_back(r);
    endfunction

    // Apply one operation to the predicted stacks and queue its results
    function automatic void predict_stack_op(input logic [tsrb_pkg::OP_W-1:0] op,
                                             input logic signed [tsrb_pkg::DATA_W-1:0] value);
        logic signed [tsrb_pkg::DATA_W-1:0] moved;
        case (op)
            tsrb_pkg::OP_PUSH: begin
                if (pri_depth >= STACK_DEPTH) begin
                    expect_result(tsrb_pkg::ST_PRI_FULL, '0, 1'b1);
                end else begin
                    pri_stack[pri_depth] = value;
                    pri_depth++;
                    expect_result(tsrb_pkg::ST_OK, value, 1'b1);
                end
            end
            tsrb_pkg::OP_POP: begin
                // empty primary wins over full bin
                if (pri_depth == 0) begin
                    expect_result(tsrb_pkg::ST_PRI_EMPTY, '0, 1'b1);
                end else if (bin_depth >= STACK_DEPTH) begin
                    expect_result(tsrb_pkg::ST_BIN_FULL, '0, 1'b1);
                end else begin
                    pri_depth--;
                    moved = pri_stack[pri_depth];
                    bin_stack[bin_depth] = moved;
                    bin_depth++;
                    expect_result(tsrb_pkg::ST_OK, moved, 1'b1);
                end
            end
            tsrb_pkg::OP_RESTORE: begin
                // empty bin wins over full primary
                if (bin_depth == 0) begin
                    expect_result(tsrb_pkg::ST_BIN_EMPTY, '0, 1'b1);
                end else if (pri_depth >= STACK_DEPTH) begin
                    expect_result(tsrb_pkg::ST_PRI_FULL, '0, 1'b1);
                end else begin
                    bin_depth--;
                    moved = bin_stack[bin_depth];
                    pri_stack[pri_depth] = moved;
                    pri_depth++;
                    expect_result(tsrb_pkg::ST_OK, moved, 1'b1);
                end
            end
            tsrb_pkg::OP_DISCARD: begin
                if (bin_depth == 0) begin
                    expect_result(tsrb_pkg::ST_BIN_EMPTY, '0, 1'b1);
                end else begin
                    bin_depth--;
                    expect_result(tsrb_pkg::ST_OK, bin_stack[bin_depth], 1'b1);
                end
            end
            tsrb_pkg::OP_SHOW_PRI: begin
                if (pri_depth == 0) begin
                    expect_result(tsrb_pkg::ST_PRI_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = pri_depth - 1; i >= 0; i--)
                        expect_result(tsrb_pkg::ST_OK, pri_stack[i], i == 0);
                end
            end
            tsrb_pkg::OP_SHOW_BIN: begin
                if (bin_depth == 0) begin
                    expect_result(tsrb_pkg::ST_BIN_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = bin_depth - 1; i >= 0; i--)
                        expect_result(tsrb_pkg::ST_OK, bin_stack[i], i == 0);
                end
            end
            default: begin
                expect_result(tsrb_pkg::ST_BAD_OP, '0, 1'b1);
            end
        endcase
    endfunction

    // Offer one item, idling first at random; starts and ends at a falling edge
    task automatic send_item(input logic [tsrb_pkg::OP_W-1:0] op,
                             input logic signed [tsrb_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.push_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_stack_op(op, value);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Lower valid and wait until every predicted result has been seen
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [tsrb_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [tsrb_pkg::OP_W-1:0] rand_op(input t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 45) return tsrb_pkg::OP_PUSH;
                if (r < 68) return tsrb_pkg::OP_POP;
                if (r < 78) return tsrb_pkg::OP_RESTORE;
                if (r < 83) return tsrb_pkg::OP_DISCARD;
                if (r < 90) return tsrb_pkg::OP_SHOW_PRI;
                if (r < 97) return tsrb_pkg::OP_SHOW_BIN;
            end
            MIX_BIN_FILL: begin
                if (r < 32) return tsrb_pkg::OP_PUSH;
                if (r < 77) return tsrb_pkg::OP_POP;
                if (r < 81) return tsrb_pkg::OP_RESTORE;
                if (r < 85) return tsrb_pkg::OP_DISCARD;
                if (r < 91) return tsrb_pkg::OP_SHOW_PRI;
                if (r < 97) return tsrb_pkg::OP_SHOW_BIN;
            end
            default: begin
                if (r < 15) return tsrb_pkg::OP_PUSH;
                if (r < 35) return tsrb_pkg::OP_POP;
                if (r < 52) return tsrb_pkg::OP_RESTORE;
                if (r < 75) return tsrb_pkg::OP_DISCARD;
                if (r < 85) return tsrb_pkg::OP_SHOW_PRI;
                if (r < 95) return tsrb_pkg::OP_SHOW_BIN;
            end
        endcase
        return $urandom_range(1) ? OP_BAD_HI : OP_BAD_LO;
    endfunction

    // Bad opcodes and every operation but push on empty stacks
    task automatic test_empty_and_bad();
        send_item(OP_BAD_LO, 32'sh7fff_ffff);
        send_item(OP_BAD_HI, 32'sh8000_0000);
        send_item(tsrb_pkg::OP_SHOW_PRI, '0);
        send_item(tsrb_pkg::OP_SHOW_BIN, '0);
        send_item(tsrb_pkg::OP_POP, '0);
        send_item(tsrb_pkg::OP_RESTORE, '0);
        send_item(tsrb_pkg::OP_DISCARD, '0);
        drain_results();
    endtask

    // Fill both stacks and hit each full case and the pop priority case
    task automatic test_full_stacks();
        logic signed [tsrb_pkg::DATA_W-1:0] edge_values [STACK_DEPTH];
        edge_values = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                        32'shaaaa_aaaa, 32'sh5555_5555, 32'sh0000_0001, 32'shfffe_0001};
        foreach (edge_values[i]) send_item(tsrb_pkg::OP_PUSH, edge_values[i]);
        send_item(tsrb_pkg::OP_PUSH, 32'sh1234_5678);
        send_item(tsrb_pkg::OP_SHOW_PRI, '0);
        // restore into a full primary
        send_item(tsrb_pkg::OP_POP, '0);
        send_item(tsrb_pkg::OP_PUSH, 32'sh0f0f_0f0f);
        send_item(tsrb_pkg::OP_RESTORE, '0);
        send_item(tsrb_pkg::OP_DISCARD, '0);
        // fill the bin, then pop from an empty primary and into a full bin
        repeat (STACK_DEPTH) send_item(tsrb_pkg::OP_POP, '0);
        send_item(tsrb_pkg::OP_POP, '0);
        send_item(tsrb_pkg::OP_PUSH, -32'sd2);
        send_item(tsrb_pkg::OP_POP, '0);
        send_item(tsrb_pkg::OP_SHOW_BIN, '0);
        drain_results();
    endtask

    // Stall the output for a long stretch while items keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        send_item(tsrb_pkg::OP_SHOW_PRI, '0);
        send_item(tsrb_pkg::OP_SHOW_BIN, '0);
        for (int k = 0; k < 30; k++) send_item(rand_op(t_mix'(k % 3)), rand_value());
        drain_results();
    endtask

    // Random operation streams under one idling setting
    task automatic test_random_phase(input int n_items, input int idle_pct,
                                     input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int k = 0; k < n_items; k++)
            send_item(rand_op(t_mix'((k / 24) % 3)), rand_value());
        drain_results();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = '0;
        in_ch.push_value = '0;
        out_ch.ready     = 1'b0;
        pri_depth        = 0;
        bin_depth        = 0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_and_bad();
        send_idle_pct = 46;
        stall_pct     = 46;
        test_full_stacks();
        test_random_phase(90, 0, 0);
        test_random_phase(90, 46, 0);
        test_random_phase(90, 0, 46);
        test_random_phase(90, 15, 15);
        test_output_backpressure();

        $display("Covered %0d items and %0d results under four idling mixes and a long stall",
                 items_sent, results_checked);
        $display("Statuses seen ok/pf/pe/bf/be/bad: %0b%0b%0b%0b%0b%0b",
                 status_seen[tsrb_pkg::ST_OK], status_seen[tsrb_pkg::ST_PRI_FULL],
                 status_seen[tsrb_pkg::ST_PRI_EMPTY], status_seen[tsrb_pkg::ST_BIN_FULL],
                 status_seen[tsrb_pkg::ST_BIN_EMPTY], status_seen[tsrb_pkg::ST_BAD_OP]);
        if (error_count == 0) begin
            $display("twin_stack_with_recycle_bin_top_tb: done, clean");
        end else begin
            $display("twin_stack_with_recycle_bin_top_tb: done, errors");
        end
        $finish;
    end

endmodule
